@@ design/lkf_pkg.sv @@
// ----------------------------------------------------------------------------
// lkf_pkg
// Shared types, codes and saturating helpers of the linear Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none
package lkf_pkg;

	localparam int WORD_W  = 32;
	localparam int MAX_DIM = 4;
	localparam int ACC_W   = 64;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic [2:0]               dim_t;

	localparam logic [2:0] FN_LOAD      = 3'd0;
	localparam logic [2:0] FN_INIT_ZERO = 3'd1;
	localparam logic [2:0] FN_INIT_GIV  = 3'd2;
	localparam logic [2:0] FN_PREDICT   = 3'd3;
	localparam logic [2:0] FN_UPDATE    = 3'd4;
	localparam logic [2:0] FN_PRED_UPD  = 3'd5;
	localparam logic [2:0] FN_REPLACE   = 3'd6;

	localparam logic [2:0] MS_A  = 3'd0;
	localparam logic [2:0] MS_C  = 3'd1;
	localparam logic [2:0] MS_Q  = 3'd2;
	localparam logic [2:0] MS_R  = 3'd3;
	localparam logic [2:0] MS_P0 = 3'd4;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NOINIT   = 2'd1;
	localparam logic [1:0] STAT_SINGULAR = 2'd2;

	localparam logic REG_STATE_DIM = 1'b0;
	localparam logic REG_MEAS_DIM  = 1'b1;

	localparam word_t WORD_MAX = 32'sh7fffffff;
	localparam word_t WORD_MIN = 32'sh80000000;
	localparam acc_t  ACC_MAX  = 64'sd2147483647;
	localparam acc_t  ACC_MIN  = -64'sd2147483648;

	typedef struct packed {
		logic [2:0]               func;
		logic [2:0]               matrix_sel;
		logic [1:0]               row;
		logic [1:0]               col;
		word_t                    coef_value;
		word_t [MAX_DIM-1:0]      elem;
	} item_t;

	typedef struct packed {
		logic [1:0]               status;
		word_t [MAX_DIM-1:0]      est;
	} res_t;

	function automatic word_t sat_acc(input acc_t v);
		word_t r;
		if (v > ACC_MAX) begin
			r = WORD_MAX;
		end else if (v < ACC_MIN) begin
			r = WORD_MIN;
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

	function automatic word_t sat_add(input word_t a, input word_t b);
		logic signed [WORD_W:0] s;
		word_t r;
		s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1]) begin
			r = s[WORD_W] ? WORD_MIN : WORD_MAX;
		end else begin
			r = s[WORD_W-1:0];
		end
		return r;
	endfunction

	function automatic word_t sat_sub(input word_t a, input word_t b);
		logic signed [WORD_W:0] s;
		word_t r;
		s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1]) begin
			r = s[WORD_W] ? WORD_MIN : WORD_MAX;
		end else begin
			r = s[WORD_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [WORD_W:0] mag(input word_t v);
		logic signed [WORD_W:0] e;
		e = {v[WORD_W-1], v};
		return (e < 0) ? (-e) : e;
	endfunction

endpackage
`default_nettype wire

@@ design/lkf_mul.sv @@
// ----------------------------------------------------------------------------
// lkf_mul
// Shared fixed-point multiplier: registered product, rounded half up.
// ----------------------------------------------------------------------------
`default_nettype none
module lkf_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  lkf_pkg::word_t a,
	input  lkf_pkg::word_t b,
	output lkf_pkg::acc_t  raw_s1
);
	import lkf_pkg::*;

	localparam acc_t HALF = 64'sd1 <<< (FRAC_BITS - 1);

	acc_t prod;

	assign prod = acc_t'(a) * acc_t'(b);

	always_ff @(posedge clk) begin
		raw_s1 <= (prod + HALF) >>> FRAC_BITS;
	end

endmodule
`default_nettype wire

@@ design/lkf_div.sv @@
// ----------------------------------------------------------------------------
// lkf_div
// Radix-2 restoring divider: (a << FRAC_BITS) / b, truncated, saturated.
// ----------------------------------------------------------------------------
`default_nettype none
module lkf_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lkf_pkg::word_t a,
	input  lkf_pkg::word_t b,
	output logic           done,
	output lkf_pkg::word_t q
);
	import lkf_pkg::*;

	localparam int NW  = WORD_W + FRAC_BITS;
	localparam int CW  = $clog2(NW + 1);
	localparam logic [NW-1:0] POS_LIM = NW'(33'h07fffffff);
	localparam logic [NW-1:0] NEG_LIM = NW'(33'h080000000);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [NW-1:0]   num_q;
	logic [NW-1:0]   quo_q;
	logic [WORD_W:0] rem_q;
	logic [WORD_W:0] den_q;
	logic            neg_q;
	logic [WORD_W:0] rem_sh;
	logic [WORD_W:0] a_mag;

	assign a_mag  = mag(a);
	assign rem_sh = {rem_q[WORD_W-1:0], num_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NW'(a_mag) << FRAC_BITS;
			den_q <= mag(b);
			neg_q <= a[WORD_W-1] ^ b[WORD_W-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (rem_sh >= den_q) begin
				rem_q <= rem_sh - den_q;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (!neg_q) begin
			q = (quo_q > POS_LIM) ? WORD_MAX : quo_q[WORD_W-1:0];
		end else begin
			q = (quo_q > NEG_LIM) ? WORD_MIN : (-quo_q[WORD_W-1:0]);
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

@@ design/lkf_core.sv @@
// ----------------------------------------------------------------------------
// lkf_core
// Sequencer, matrix storage and Gauss-Jordan control around the shared units.
// ----------------------------------------------------------------------------
`default_nettype none
module lkf_core #(
	parameter int STATE_SIZE = 4,
	parameter int MEAS_SIZE  = 2,
	parameter int FRAC_BITS  = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lkf_pkg::item_t item,
	input  lkf_pkg::dim_t  n_dim,
	input  lkf_pkg::dim_t  m_dim,
	output logic           busy,
	output logic           res_valid,
	input  logic           res_ready,
	output lkf_pkg::res_t  res
);
	import lkf_pkg::*;

	localparam word_t ONE = 32'sd1 <<< FRAC_BITS;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_ACC, ST_PCOPY, ST_GJ_INIT, ST_GJ_SCAN, ST_GJ_SWAP,
		ST_GJ_DIVS, ST_GJ_DIVW, ST_GJ_EROW, ST_GJ_EMUL, ST_GJ_EACC, ST_UCOPY,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		PH_X, PH_AP, PH_APA, PH_PC, PH_S, PH_KG, PH_NU, PH_IKC, PH_NP, PH_XU
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	item_t  item_q;
	logic   ready_q;
	logic   sing_q;
	logic [2:0] i_q, j_q, k_q, sc_q;
	logic [1:0] c_q, best_q;
	logic [WORD_W:0] bmag_q;
	word_t  piv_q, f_q;
	acc_t   acc_q;

	word_t a_m  [MAX_DIM][MAX_DIM];
	word_t c_m  [MAX_DIM][MAX_DIM];
	word_t q_m  [MAX_DIM][MAX_DIM];
	word_t r_m  [MAX_DIM][MAX_DIM];
	word_t p0_m [MAX_DIM][MAX_DIM];
	word_t p_m  [MAX_DIM][MAX_DIM];
	word_t ap_m [MAX_DIM][MAX_DIM];
	word_t pc_m [MAX_DIM][MAX_DIM];
	word_t kg_m [MAX_DIM][MAX_DIM];
	word_t ikc_m[MAX_DIM][MAX_DIM];
	word_t s_m  [MAX_DIM][2*MAX_DIM];
	word_t xs_v [MAX_DIM];
	word_t tx_v [MAX_DIM];
	word_t nu_v [MAX_DIM];

	word_t mul_a, mul_b;
	acc_t  raw_s1;
	acc_t  acc_next;
	word_t acc_sat;
	logic  div_start, div_done;
	word_t div_q;
	dim_t  ni, nj, nk;
	logic [1:0] ii, jj, kk;
	logic [2:0] mj;

	assign ii = i_q[1:0];
	assign jj = j_q[1:0];
	assign kk = k_q[1:0];
	assign mj = m_dim + j_q;

	lkf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk   (clk),
		.a     (mul_a),
		.b     (mul_b),
		.raw_s1(raw_s1)
	);

	lkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.a     (s_m[c_q][j_q]),
		.b     (piv_q),
		.done  (div_done),
		.q     (div_q)
	);

	assign div_start = (state_q == ST_GJ_DIVS);

	always_comb begin
		mul_a = a_m[ii][kk];
		mul_b = xs_v[kk];
		ni = n_dim;
		nj = n_dim;
		nk = n_dim;
		case (phase_q)
			PH_X: begin
				nj = 3'd1;
			end
			PH_AP: begin
				mul_b = p_m[kk][jj];
			end
			PH_APA: begin
				mul_a = ap_m[ii][kk];
				mul_b = a_m[jj][kk];
			end
			PH_PC: begin
				mul_a = p_m[ii][kk];
				mul_b = c_m[jj][kk];
				nj = m_dim;
			end
			PH_S: begin
				mul_a = c_m[ii][kk];
				mul_b = pc_m[kk][jj];
				ni = m_dim;
				nj = m_dim;
			end
			PH_KG: begin
				mul_a = pc_m[ii][kk];
				mul_b = s_m[kk][mj];
				nj = m_dim;
				nk = m_dim;
			end
			PH_NU: begin
				mul_a = c_m[ii][kk];
				mul_b = xs_v[kk];
				ni = m_dim;
				nj = 3'd1;
			end
			PH_IKC: begin
				mul_a = kg_m[ii][kk];
				mul_b = c_m[kk][jj];
				nk = m_dim;
			end
			PH_NP: begin
				mul_a = ikc_m[ii][kk];
				mul_b = p_m[kk][jj];
			end
			PH_XU: begin
				mul_a = kg_m[ii][kk];
				mul_b = nu_v[kk];
				nj = 3'd1;
				nk = m_dim;
			end
			default: begin
			end
		endcase
		if (state_q == ST_GJ_EMUL) begin
			mul_a = f_q;
			mul_b = s_m[c_q][j_q];
		end
	end

	assign acc_next = ((k_q == 3'd0) ? acc_t'(0) : acc_q) + raw_s1;
	assign acc_sat  = sat_acc(acc_next);

	// coefficient stores, no reset
	always_ff @(posedge clk) begin
		if (start && item.func == FN_LOAD) begin
			case (item.matrix_sel)
				MS_A: begin
					if (32'(item.row) < STATE_SIZE && 32'(item.col) < STATE_SIZE)
						a_m[item.row][item.col] <= item.coef_value;
				end
				MS_C: begin
					if (32'(item.row) < MEAS_SIZE && 32'(item.col) < STATE_SIZE)
						c_m[item.row][item.col] <= item.coef_value;
				end
				MS_Q: begin
					if (32'(item.row) < STATE_SIZE && 32'(item.col) < STATE_SIZE)
						q_m[item.row][item.col] <= item.coef_value;
				end
				MS_R: begin
					if (32'(item.row) < MEAS_SIZE && 32'(item.col) < MEAS_SIZE)
						r_m[item.row][item.col] <= item.coef_value;
				end
				MS_P0: begin
					if (32'(item.row) < STATE_SIZE && 32'(item.col) < STATE_SIZE)
						p0_m[item.row][item.col] <= item.coef_value;
				end
				default: begin
				end
			endcase
		end
	end

	// scratch matrices
	always_ff @(posedge clk) begin
		if (state_q == ST_ACC && k_q == nk - 3'd1) begin
			case (phase_q)
				PH_X:   tx_v[ii] <= acc_sat;
				PH_AP:  ap_m[ii][jj] <= acc_sat;
				PH_PC:  pc_m[ii][jj] <= acc_sat;
				PH_S: begin
					s_m[ii][jj] <= sat_add(acc_sat, r_m[ii][jj]);
					s_m[ii][mj] <= (i_q == j_q) ? ONE : '0;
				end
				PH_KG:  kg_m[ii][jj] <= acc_sat;
				PH_NU:  nu_v[ii] <= sat_sub(item_q.elem[ii], acc_sat);
				PH_IKC: ikc_m[ii][jj] <= sat_sub((i_q == j_q) ? ONE : '0, acc_sat);
				PH_NP:  ap_m[ii][jj] <= acc_sat;
				default: begin
				end
			endcase
		end
		if (state_q == ST_GJ_SWAP && best_q != c_q) begin
			for (int jc = 0; jc < 2 * MAX_DIM; jc++) begin
				s_m[c_q][jc]    <= s_m[best_q][jc];
				s_m[best_q][jc] <= s_m[c_q][jc];
			end
		end
		if (state_q == ST_GJ_DIVW && div_done) begin
			s_m[c_q][j_q] <= div_q;
		end
		if (state_q == ST_GJ_EACC) begin
			s_m[ii][j_q] <= sat_sub(s_m[ii][j_q], sat_acc(raw_s1));
		end
		if (state_q == ST_ACC) begin
			acc_q <= acc_next;
		end
		if (state_q == ST_GJ_SWAP) begin
			piv_q <= s_m[best_q][c_q];
		end
		if (state_q == ST_GJ_EROW) begin
			f_q <= s_m[ii][c_q];
		end
		if (state_q == ST_IDLE && start) begin
			item_q <= item;
		end
	end

	// sequencer, state vector and covariance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_X;
			ready_q <= 1'b0;
			sing_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			sc_q    <= '0;
			c_q     <= '0;
			best_q  <= '0;
			bmag_q  <= '0;
			for (int r = 0; r < MAX_DIM; r++) begin
				xs_v[r] <= '0;
				for (int c = 0; c < MAX_DIM; c++) begin
					p_m[r][c] <= '0;
				end
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						sing_q  <= 1'b0;
						state_q <= ST_DONE;
						case (item.func)
							FN_INIT_ZERO, FN_INIT_GIV: begin
								for (int r = 0; r < MAX_DIM; r++) begin
									xs_v[r] <= (item.func == FN_INIT_GIV && 3'(r) < n_dim) ?
										item.elem[r] : '0;
									for (int c = 0; c < MAX_DIM; c++) begin
										p_m[r][c] <= (3'(r) < n_dim && 3'(c) < n_dim) ?
											p0_m[r][c] : '0;
									end
								end
								ready_q <= 1'b1;
							end
							FN_PREDICT, FN_PRED_UPD: begin
								if (ready_q) begin
									phase_q <= PH_X;
									state_q <= ST_MUL;
								end
							end
							FN_UPDATE: begin
								if (ready_q) begin
									phase_q <= PH_PC;
									state_q <= ST_MUL;
								end
							end
							FN_REPLACE: begin
								if (ready_q) begin
									for (int r = 0; r < MAX_DIM; r++) begin
										xs_v[r] <= (3'(r) < n_dim) ? item.elem[r] : '0;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					state_q <= ST_MUL;
					if (k_q == nk - 3'd1) begin
						k_q <= '0;
						if (phase_q == PH_APA) begin
							p_m[ii][jj] <= sat_add(acc_sat, q_m[ii][jj]);
						end
						if (phase_q == PH_XU) begin
							xs_v[ii] <= sat_add(xs_v[ii], acc_sat);
						end
						if (j_q == nj - 3'd1) begin
							j_q <= '0;
							if (i_q == ni - 3'd1) begin
								i_q <= '0;
								case (phase_q)
									PH_X:   phase_q <= PH_AP;
									PH_AP:  phase_q <= PH_APA;
									PH_APA: state_q <= ST_PCOPY;
									PH_PC:  phase_q <= PH_S;
									PH_S: begin
										c_q     <= '0;
										state_q <= ST_GJ_INIT;
									end
									PH_KG:  phase_q <= PH_NU;
									PH_NU:  phase_q <= PH_IKC;
									PH_IKC: phase_q <= PH_NP;
									PH_NP:  phase_q <= PH_XU;
									PH_XU:  state_q <= ST_UCOPY;
									default: state_q <= ST_DONE;
								endcase
							end else begin
								i_q <= i_q + 3'd1;
							end
						end else begin
							j_q <= j_q + 3'd1;
						end
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_PCOPY: begin
					for (int r = 0; r < MAX_DIM; r++) begin
						if (3'(r) < n_dim) begin
							xs_v[r] <= tx_v[r];
						end
					end
					if (item_q.func == FN_PRED_UPD) begin
						phase_q <= PH_PC;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_GJ_INIT: begin
					best_q  <= c_q;
					bmag_q  <= mag(s_m[c_q][{1'b0, c_q}]);
					sc_q    <= {1'b0, c_q} + 3'd1;
					state_q <= ST_GJ_SCAN;
				end
				ST_GJ_SCAN: begin
					if (sc_q >= m_dim) begin
						if (s_m[best_q][{1'b0, c_q}] == '0) begin
							sing_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							j_q     <= '0;
							state_q <= ST_GJ_SWAP;
						end
					end else begin
						if (mag(s_m[sc_q[1:0]][{1'b0, c_q}]) > bmag_q) begin
							best_q <= sc_q[1:0];
							bmag_q <= mag(s_m[sc_q[1:0]][{1'b0, c_q}]);
						end
						sc_q <= sc_q + 3'd1;
					end
				end
				ST_GJ_SWAP: begin
					state_q <= ST_GJ_DIVS;
				end
				ST_GJ_DIVS: begin
					state_q <= ST_GJ_DIVW;
				end
				ST_GJ_DIVW: begin
					if (div_done) begin
						if (j_q == (m_dim << 1) - 3'd1) begin
							j_q     <= '0;
							i_q     <= '0;
							state_q <= ST_GJ_EROW;
						end else begin
							j_q     <= j_q + 3'd1;
							state_q <= ST_GJ_DIVS;
						end
					end
				end
				ST_GJ_EROW: begin
					if (i_q == m_dim) begin
						i_q <= '0;
						if ({1'b0, c_q} == m_dim - 3'd1) begin
							phase_q <= PH_KG;
							state_q <= ST_MUL;
						end else begin
							c_q     <= c_q + 2'd1;
							state_q <= ST_GJ_INIT;
						end
					end else if (ii == c_q) begin
						i_q <= i_q + 3'd1;
					end else begin
						j_q     <= '0;
						state_q <= ST_GJ_EMUL;
					end
				end
				ST_GJ_EMUL: begin
					state_q <= ST_GJ_EACC;
				end
				ST_GJ_EACC: begin
					if (j_q == (m_dim << 1) - 3'd1) begin
						j_q     <= '0;
						i_q     <= i_q + 3'd1;
						state_q <= ST_GJ_EROW;
					end else begin
						j_q     <= j_q + 3'd1;
						state_q <= ST_GJ_EMUL;
					end
				end
				ST_UCOPY: begin
					for (int r = 0; r < MAX_DIM; r++) begin
						for (int c = 0; c < MAX_DIM; c++) begin
							if (3'(r) < n_dim && 3'(c) < n_dim) begin
								p_m[r][c] <= ap_m[r][c];
							end
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res.status = !ready_q ? STAT_NOINIT : (sing_q ? STAT_SINGULAR : STAT_OK);
		for (int e = 0; e < MAX_DIM; e++) begin
			res.est[e] = (3'(e) < n_dim) ? xs_v[e] : '0;
		end
	end

endmodule
`default_nettype wire

@@ design/linear_kalman_filter.sv @@
// ----------------------------------------------------------------------------
// linear_kalman_filter
// Linear Kalman filter in signed fixed point on one shared multiplier/divider.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one command beat (load, init,
// replace, predict, update, predict+update). Output channel: out_valid/
// out_stall carry one beat per command: status and state estimate.
// Dimensions are set over the APB port; the user must write them only while
// the block is idle; the block itself does not enforce it. Loads, init and
// replace pass from the core's done state into the output register. Each
// product step runs through the MUL and ACC states on the shared
// multiplier; update adds the products and the Gauss-Jordan inverse, where
// each pivot row element goes through the serial divider.
// in_stall is high while a command is in progress; the next beat is taken
// once the result has moved into the output register. When out_stall is
// held the result waits in the core and further input stays stalled.
// Reset clears state, covariance, the initialised flag and the channels;
// coefficient matrices hold unknown values until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
module linear_kalman_filter #(
	parameter int STATE_SIZE = 4,
	parameter int MEAS_SIZE  = 2,
	parameter int FRAC_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          func,
	input  logic [2:0]          matrix_sel,
	input  logic [1:0]          row,
	input  logic [1:0]          col,
	input  logic signed [31:0]  coef_value,
	input  logic signed [31:0]  elem_0,
	input  logic signed [31:0]  elem_1,
	input  logic signed [31:0]  elem_2,
	input  logic signed [31:0]  elem_3,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic signed [31:0]  est_0,
	output logic signed [31:0]  est_1,
	output logic signed [31:0]  est_2,
	output logic signed [31:0]  est_3
);
	import lkf_pkg::*;

	dim_t  sdim_q, mdim_q, n_dim, m_dim;
	logic  out_valid_q;
	res_t  out_q;
	item_t item;
	logic  busy, res_valid, res_ready, accept;
	res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sdim_q <= 3'd4;
			mdim_q <= 3'd2;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_STATE_DIM) begin
				sdim_q <= pwdata[2:0];
			end else begin
				mdim_q <= pwdata[2:0];
			end
		end
	end

	assign pready = 1'b1;
	assign prdata = {29'd0, (paddr[2] == REG_STATE_DIM) ? sdim_q : mdim_q};

	assign n_dim = (sdim_q == 3'd0) ? 3'd1 :
		(32'(sdim_q) > STATE_SIZE) ? 3'(STATE_SIZE) : sdim_q;
	assign m_dim = (mdim_q == 3'd0) ? 3'd1 :
		(32'(mdim_q) > MEAS_SIZE) ? 3'(MEAS_SIZE) : mdim_q;

	assign item.func       = func;
	assign item.matrix_sel = matrix_sel;
	assign item.row        = row;
	assign item.col        = col;
	assign item.coef_value = coef_value;
	assign item.elem       = {elem_3, elem_2, elem_1, elem_0};

	assign in_stall = busy;
	assign accept   = in_valid && !busy;

	lkf_core #(
		.STATE_SIZE(STATE_SIZE),
		.MEAS_SIZE (MEAS_SIZE),
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.item     (item),
		.n_dim    (n_dim),
		.m_dim    (m_dim),
		.busy     (busy),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign est_0     = out_q.est[0];
	assign est_1     = out_q.est[1];
	assign est_2     = out_q.est[2];
	assign est_3     = out_q.est[3];

endmodule
`default_nettype wire

@@ design/lkf_chk.sv @@
// ----------------------------------------------------------------------------
// lkf_chk
// Port-level checks of the Kalman filter channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module lkf_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         status,
	input logic signed [31:0] est_0
);

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("no busy after input beat");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without command in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status code");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(est_0))
		else $error("stalled result changed");

endmodule

bind linear_kalman_filter lkf_chk u_lkf_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.status   (status),
	.est_0    (est_0)
);
`default_nettype wire
